/* hdl/modular_inverse_ext_euclid_top_assert.svh */
// assertion macros for the modular inverse block and its checker
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mie: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define MIE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mie: next-cycle check failed");

`endif

/* hdl/mie_pkg.sv */
// shared types for the modular inverse block
package mie_pkg;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_RED  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

endpackage

/* hdl/mie_in_if.sv */
// input channel: operand and modulus with valid/ready
interface mie_in_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] operand;
    logic [W-1:0] modulus;

    modport source (output valid, output operand, output modulus, input ready);
    modport sink   (input valid, input operand, input modulus, output ready);
endinterface

/* hdl/mie_out_if.sv */
// output channel: inverse, gcd and flag with valid/ready
interface mie_out_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
    logic         not_invertible;

    modport source (output valid, output inverse, output divisor, output not_invertible,
                    input ready);
    modport sink   (input valid, input inverse, input divisor, input not_invertible,
                    output ready);
endinterface

/* hdl/mie_div.sv */
// radix-2 restoring divider with a shift-add accumulator for quotient times multiplier
module mie_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    input  logic [W-1:0] i_mult,
    output logic         o_done,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_acc
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [W-1:0]  r_mult, n_mult;
    logic [W-1:0]  r_acc, n_acc;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          qbit;

    // one quotient bit per cycle, msb first
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign qbit   = ~diff[W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_mult = r_mult;
        n_acc  = r_acc;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_mult = i_mult;
            n_acc  = '0;
        end else if (r_busy) begin
            n_rem = qbit ? diff[W-1:0] : rem_sh[W-1:0];
            n_quo = {r_quo[W-2:0], qbit};
            // acc = 2*acc + qbit*mult, modulo 2^W
            n_acc = {r_acc[W-2:0], 1'b0} + (qbit ? r_mult : '0);
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_mult <= n_mult;
        r_acc  <= n_acc;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule

/* hdl/modular_inverse_ext_euclid_top.sv */
// modular inverse by the extended euclidean algorithm, top level
//
// usage
// - input channel i_in carries operand and modulus; an item is taken when valid and
//   ready are both high at a rising edge of i_clk
// - output channel o_out carries inverse (coefficient of operand reduced into
//   0..modulus-1), divisor (the gcd) and not_invertible (gcd not 1, or zero modulus)
// - one item at a time: i_in.ready is high only while idle, and stays low until the
//   result has been taken from o_out
// - each euclid step is one division in the shared radix-2 divider, which also
//   forms quotient times coefficient by shift-add; the final reduction of the
//   coefficient is one more division
// - the result is offered once the final reduction is done; for 32-bit values there
//   are at most about 46 steps, far fewer for small or easy operands
// - a zero modulus skips the loop: the result is offered in the cycle after the item
// - the next item can be taken in the cycle after the result has left
// - the result sits in output registers while o_out.ready is low; nothing else moves
// - synchronous active-low reset returns the sequencer to idle and drops any item
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mie_in_if.sink  i_in,
    mie_out_if.source o_out
);

    mie_pkg::t_state r_state, n_state;

    // remainder pair, coefficient magnitudes and step parity
    logic [WIDTH-1:0] r_prev, n_prev;
    logic [WIDTH-1:0] r_cur, n_cur;
    logic [WIDTH-1:0] r_s_prev, n_s_prev;
    logic [WIDTH-1:0] r_s_cur, n_s_cur;
    logic             r_par, n_par;
    logic [WIDTH-1:0] r_mod, n_mod;

    // result registers
    logic [WIDTH-1:0] r_inv, n_inv;
    logic [WIDTH-1:0] r_gcd, n_gcd;
    logic             r_ni, n_ni;

    // shared divider hookup
    logic             div_start;
    logic [WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0] div_divisor;
    logic [WIDTH-1:0] div_mult;
    logic             div_done;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH-1:0] div_acc;

    mie_div #(
        .W (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mult     (div_mult),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_acc      (div_acc)
    );

    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_s_prev     = r_s_prev;
        n_s_cur      = r_s_cur;
        n_par        = r_par;
        n_mod        = r_mod;
        n_inv        = r_inv;
        n_gcd        = r_gcd;
        n_ni         = r_ni;
        div_start    = 1'b0;
        div_dividend = r_prev;
        div_divisor  = r_cur;
        div_mult     = r_s_cur;

        unique case (r_state)
            mie_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.modulus == '0) begin
                        // zero modulus: gcd is the operand, nothing to invert
                        n_inv   = '0;
                        n_gcd   = i_in.operand;
                        n_ni    = 1'b1;
                        n_state = mie_pkg::ST_OUT;
                    end else begin
                        // r0 = a, r1 = m, s0 = 1, s1 = 0
                        n_prev   = i_in.operand;
                        n_cur    = i_in.modulus;
                        n_mod    = i_in.modulus;
                        n_s_prev = WIDTH'(1);
                        n_s_cur  = '0;
                        n_par    = 1'b0;
                        n_state  = mie_pkg::ST_LOOP;
                    end
                end
            end
            mie_pkg::ST_LOOP: begin
                div_start = 1'b1;
                if (r_cur == '0) begin
                    // remainders exhausted: reduce the gcd's coefficient mod m
                    div_dividend = r_s_prev;
                    div_divisor  = r_mod;
                    div_mult     = '0;
                    n_state      = mie_pkg::ST_RED;
                end else begin
                    n_state = mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_DIV: begin
                if (div_done) begin
                    // |s(i+1)| = |s(i-1)| + q * |s(i)|
                    n_prev   = r_cur;
                    n_cur    = div_rem;
                    n_s_prev = r_s_cur;
                    n_s_cur  = r_s_prev + div_acc;
                    n_par    = ~r_par;
                    n_state  = mie_pkg::ST_LOOP;
                end
            end
            mie_pkg::ST_RED: begin
                if (div_done) begin
                    // odd index means a negative coefficient
                    if (!r_par || div_rem == '0) begin
                        n_inv = div_rem;
                    end else begin
                        n_inv = r_mod - div_rem;
                    end
                    n_gcd   = r_prev;
                    n_ni    = (r_prev != WIDTH'(1));
                    n_state = mie_pkg::ST_OUT;
                end
            end
            mie_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = mie_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mie_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_s_prev <= n_s_prev;
        r_s_cur  <= n_s_cur;
        r_par    <= n_par;
        r_mod    <= n_mod;
        r_inv    <= n_inv;
        r_gcd    <= n_gcd;
        r_ni     <= n_ni;
    end

    // handshake straight from the sequencer state
    assign i_in.ready           = (r_state == mie_pkg::ST_IDLE);
    assign o_out.valid          = (r_state == mie_pkg::ST_OUT);
    assign o_out.inverse        = r_inv;
    assign o_out.divisor        = r_gcd;
    assign o_out.not_invertible = r_ni;

endmodule

/* hdl/mie_checker.sv */
// port-level checker for the modular inverse block, with its bind
`include "modular_inverse_ext_euclid_top_assert.svh"

module mie_port_checker #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_inverse,
    input logic [W-1:0] i_divisor,
    input logic         i_not_inv
);

    // one item in flight: never ready while a result is offered
    `MIE_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, i_in_ready, !i_out_valid)
    // a taken item makes the block busy
    `MIE_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready,
                    !i_in_ready)
    // a delivered result frees the block
    `MIE_ASSERT_NXT(a_idle_after_result, i_clk, i_rst_n, i_out_valid && i_out_ready,
                    i_in_ready && !i_out_valid)
    // a clear flag only comes with a gcd of one
    `MIE_ASSERT_IMP(a_flag_gcd, i_clk, i_rst_n, i_out_valid && !i_not_inv,
                    i_divisor == W'(1))
    // a stalled result holds
    `MIE_ASSERT_NXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                    i_out_valid && $stable(i_inverse) && $stable(i_divisor))

endmodule

bind modular_inverse_ext_euclid_top mie_port_checker #(
    .W (WIDTH)
) u_mie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_inverse   (o_out.inverse),
    .i_divisor   (o_out.divisor),
    .i_not_inv   (o_out.not_invertible)
);
